### sv/coolant_pi_fan_duty_controller_top_defines.svh
// Assertion macros used by the checker file of the fan duty controller.
`ifndef COOLANT_PI_FAN_DUTY_CONTROLLER_TOP_DEFINES_SVH
`define COOLANT_PI_FAN_DUTY_CONTROLLER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPFD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cpfd check failed");

// The consequent must hold in the cycle after the antecedent.
`define CPFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cpfd check failed");

`endif

### sv/cpfd_pkg.sv
package cpfd_pkg;

  localparam int unsigned PC_W      = 3;
  localparam int unsigned ERR_W     = 18;
  localparam int unsigned GAP_W     = 11;
  localparam int unsigned EG_W      = ERR_W + GAP_W;
  localparam int unsigned ACC_W     = 40;
  localparam int unsigned INT_W     = ACC_W + 2;
  localparam int unsigned OPND_W    = 33;
  localparam int unsigned PROD_W    = 2 * OPND_W;
  localparam int unsigned PG_W      = 34;
  localparam int unsigned PI_W      = 55;
  localparam int unsigned DUTY_W    = 8;
  localparam int unsigned FRAC_W    = 12;
  localparam int unsigned DF_W      = DUTY_W + FRAC_W;
  localparam int unsigned ILO_SHIFT = 20;

  localparam logic [31:0]        GAP_MAX     = 32'd1000;
  localparam logic [GAP_W-1:0]   GAP_DEFAULT = 11'd100;
  localparam logic signed [15:0] WATER_LO    = 16'sd16;
  localparam logic signed [15:0] WATER_HI    = 16'sd1600;

  localparam logic signed [11:0] RST_TARGET    = 12'sd480;
  localparam logic [15:0]        RST_PGAIN     = 16'd1024;
  localparam logic [31:0]        RST_IGAIN     = 32'd65536;
  localparam logic [39:0]        RST_ILIMIT    = 40'd16000000;
  localparam logic [7:0]         RST_FLOOR     = 8'd60;
  localparam logic [7:0]         RST_CEILING   = 8'd255;
  localparam logic [15:0]        RST_PSU_RATIO = 16'd4096;
  localparam logic [15:0]        RST_AUX_RATIO = 16'd4096;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PREP,
    OP_INTEG,
    OP_PI_P,
    OP_PI_LO,
    OP_PI_HI,
    OP_MAIN,
    OP_FINISH
  } op_e;

  typedef enum logic [2:0] {
    A_ERR,
    A_PGAIN,
    A_IGAIN,
    A_PSU,
    A_AUX
  } asel_e;

  typedef enum logic [2:0] {
    B_GAP,
    B_ERR,
    B_LO,
    B_HI,
    B_LED
  } bsel_e;

  typedef enum logic [1:0] {
    COND_NEVER,
    COND_NO_INPUT,
    COND_OUT_BUSY
  } cond_e;

  typedef enum logic [2:0] {
    REG_TARGET,
    REG_PGAIN,
    REG_IGAIN,
    REG_ILIMIT,
    REG_FLOOR,
    REG_CEILING,
    REG_PSU_RATIO,
    REG_AUX_RATIO
  } reg_e;

  typedef struct packed {
    op_e             op;
    asel_e           a_sel;
    bsel_e           b_sel;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic signed [11:0] target;
    logic [15:0]        prop_gain;
    logic [31:0]        integ_gain;
    logic [39:0]        integral_limit;
    logic [7:0]         duty_floor;
    logic [7:0]         duty_ceiling;
    logic [15:0]        psu_ratio;
    logic [15:0]        aux_ratio;
  } cfg_t;

  typedef struct packed {
    logic [DUTY_W-1:0] main_duty;
    logic [DUTY_W-1:0] psu_duty;
    logic [DUTY_W-1:0] aux_duty;
    logic [DUTY_W-1:0] pump_duty;
    logic              water_valid;
  } res_t;

  // Microprogram: one control word per step. A step branches to its target
  // while its condition holds, otherwise it moves on to the next step.
  function automatic ctrl_t ucode(logic [PC_W-1:0] pc);
    ctrl_t c;
    c = '{op: OP_NONE, a_sel: A_ERR, b_sel: B_GAP, cond: COND_NEVER, target: '0};
    unique case (pc)
      3'd0: c = '{op: OP_PREP,   a_sel: A_ERR,   b_sel: B_GAP, cond: COND_NO_INPUT,
                  target: 3'd0};
      3'd1: c = '{op: OP_NONE,   a_sel: A_ERR,   b_sel: B_GAP, cond: COND_NEVER,
                  target: 3'd0};
      3'd2: c = '{op: OP_INTEG,  a_sel: A_PGAIN, b_sel: B_ERR, cond: COND_NEVER,
                  target: 3'd0};
      3'd3: c = '{op: OP_PI_P,   a_sel: A_IGAIN, b_sel: B_LO,  cond: COND_NEVER,
                  target: 3'd0};
      3'd4: c = '{op: OP_PI_LO,  a_sel: A_IGAIN, b_sel: B_HI,  cond: COND_NEVER,
                  target: 3'd0};
      3'd5: c = '{op: OP_PI_HI,  a_sel: A_PSU,   b_sel: B_LED, cond: COND_NEVER,
                  target: 3'd0};
      3'd6: c = '{op: OP_MAIN,   a_sel: A_AUX,   b_sel: B_LED, cond: COND_NEVER,
                  target: 3'd0};
      3'd7: c = '{op: OP_FINISH, a_sel: A_AUX,   b_sel: B_LED, cond: COND_OUT_BUSY,
                  target: 3'd7};
    endcase
    return c;
  endfunction

endpackage

### sv/coolant_pi_fan_duty_controller_top.sv
// Coolant PI fan duty controller.
// One transfer on the slave stream is one control tick. s_axis_tdata carries
// now_ms, water_temp and led_duty; the block answers each tick with one
// transfer on the master stream carrying the four fan and pump duties in
// m_axis_tdata and the water reading flag in m_axis_tuser.
// A small microprogram of eight steps runs every tick on one shared
// 33 by 33 bit multiplier, and the result of a tick is loaded into the output
// register in its last step; a new tick is not taken before the program
// has finished the last one.
// The input is ready only in the first step of the program. The output
// register frees the input side: a new tick may be taken while a result
// still waits, and if the receiver stalls that long the program holds in its
// last step until the output register is taken.
// The APB port writes the eight registers, over a 64 bit data bus, at byte address 8*i;
// writes are meant for idle periods. Reset restores the register defaults,
// clears the integral and the last time stamp and empties the output.
module coolant_pi_fan_duty_controller_top #(
  parameter int unsigned AUX_FLOOR   = 80,
  parameter int unsigned AUX_CEILING = 255,
  parameter int unsigned PUMP_FULL   = 255,
  parameter int unsigned PUMP_IDLE   = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // now_ms[31:0], water_temp[47:32], led_duty[63:48]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // main[7:0], psu[15:8], aux[23:16], pump[31:24]
  output logic        m_axis_tuser,   // water_valid[0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import cpfd_pkg::*;

  logic [PC_W-1:0] pc_q, pc_d;
  ctrl_t           ctrl;
  logic            in_xfer, out_busy, out_load, branch;
  cfg_t            cfg_q;
  res_t            res;
  logic            m_valid_q;
  logic [31:0]     m_data_q;
  logic            m_user_q;
  reg_e            reg_idx;

  assign pready        = 1'b1;
  assign reg_idx       = reg_e'(paddr[5:3]);
  assign s_axis_tready = (pc_q == '0);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_busy      = m_valid_q && !m_axis_tready;
  assign ctrl          = ucode(pc_q);
  assign out_load      = (ctrl.op == OP_FINISH) && !out_busy;

  always_comb begin
    case (ctrl.cond)
      COND_NO_INPUT: branch = !s_axis_tvalid;
      COND_OUT_BUSY: branch = out_busy;
      default:       branch = 1'b0;
    endcase
    pc_d = branch ? ctrl.target : PC_W'(pc_q + 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else begin
      pc_q <= pc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target         <= RST_TARGET;
      cfg_q.prop_gain      <= RST_PGAIN;
      cfg_q.integ_gain     <= RST_IGAIN;
      cfg_q.integral_limit <= RST_ILIMIT;
      cfg_q.duty_floor     <= RST_FLOOR;
      cfg_q.duty_ceiling   <= RST_CEILING;
      cfg_q.psu_ratio      <= RST_PSU_RATIO;
      cfg_q.aux_ratio      <= RST_AUX_RATIO;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_TARGET:    cfg_q.target         <= $signed(pwdata[11:0]);
        REG_PGAIN:     cfg_q.prop_gain      <= pwdata[15:0];
        REG_IGAIN:     cfg_q.integ_gain     <= pwdata[31:0];
        REG_ILIMIT:    cfg_q.integral_limit <= pwdata[39:0];
        REG_FLOOR:     cfg_q.duty_floor     <= pwdata[7:0];
        REG_CEILING:   cfg_q.duty_ceiling   <= pwdata[7:0];
        REG_PSU_RATIO: cfg_q.psu_ratio      <= pwdata[15:0];
        REG_AUX_RATIO: cfg_q.aux_ratio      <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TARGET:    prdata = 64'(cfg_q.target);
      REG_PGAIN:     prdata = 64'(cfg_q.prop_gain);
      REG_IGAIN:     prdata = 64'(cfg_q.integ_gain);
      REG_ILIMIT:    prdata = 64'(cfg_q.integral_limit);
      REG_FLOOR:     prdata = 64'(cfg_q.duty_floor);
      REG_CEILING:   prdata = 64'(cfg_q.duty_ceiling);
      REG_PSU_RATIO: prdata = 64'(cfg_q.psu_ratio);
      REG_AUX_RATIO: prdata = 64'(cfg_q.aux_ratio);
    endcase
  end

  cpfd_datapath #(
    .AUX_FLOOR  (AUX_FLOOR),
    .AUX_CEILING(AUX_CEILING),
    .PUMP_FULL  (PUMP_FULL),
    .PUMP_IDLE  (PUMP_IDLE)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .in_xfer_i   (in_xfer),
    .cfg_i       (cfg_q),
    .now_ms_i    (s_axis_tdata[31:0]),
    .water_temp_i($signed(s_axis_tdata[47:32])),
    .led_duty_i  (s_axis_tdata[63:48]),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {res.pump_duty, res.aux_duty, res.psu_duty, res.main_duty};
      m_user_q <= res.water_valid;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

### sv/cpfd_datapath.sv
module cpfd_datapath #(
  parameter int unsigned AUX_FLOOR   = 80,
  parameter int unsigned AUX_CEILING = 255,
  parameter int unsigned PUMP_FULL   = 255,
  parameter int unsigned PUMP_IDLE   = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cpfd_pkg::ctrl_t    ctrl_i,
  input  logic               in_xfer_i,
  input  cpfd_pkg::cfg_t     cfg_i,
  input  logic [31:0]        now_ms_i,
  input  logic signed [15:0] water_temp_i,
  input  logic [15:0]        led_duty_i,
  output cpfd_pkg::res_t     res_o
);
  import cpfd_pkg::*;

  logic [31:0]              last_time_q;
  logic [ACC_W-1:0]         acc_q, acc_d;
  logic signed [ERR_W-1:0]  err_q, err_d;
  logic [GAP_W-1:0]         gap_q, gap_d;
  logic [15:0]              led_q;
  logic                     wvalid_q, wvalid_d;
  logic signed [PROD_W-1:0] p_q;
  logic signed [PI_W-1:0]   pi_q;
  logic [DUTY_W-1:0]        main_q, main_d;
  logic [DUTY_W-1:0]        auxfb_q, auxfb_d;
  logic [DUTY_W-1:0]        psu_q;

  logic [31:0]              gap_raw;
  logic signed [OPND_W-1:0] opa, opb;
  logic                     integ_en;
  logic signed [INT_W-1:0]  integ_sum, integ_lim;
  logic signed [PI_W:0]     main_sum, main_cap, aux_sum, aux_cap;
  logic [DF_W-1:0]          main_clamp;
  logic                     led_on;
  logic [DUTY_W-1:0]        aux_led, main_out;

  function automatic logic [DUTY_W-1:0] led_scale(logic [31:0] t);
    logic [39:0] s;
    s = {t, 8'b0} - {8'b0, t};
    return (s[39:28] > 12'd255) ? '1 : s[35:28];
  endfunction

  always_comb begin
    err_d    = $signed({{2{water_temp_i[15]}}, water_temp_i})
             - $signed({{6{cfg_i.target[11]}}, cfg_i.target});
    gap_raw  = now_ms_i - last_time_q;
    gap_d    = (gap_raw == 32'd0 || gap_raw > GAP_MAX) ? GAP_DEFAULT
                                                       : gap_raw[GAP_W-1:0];
    wvalid_d = (water_temp_i > WATER_LO) && (water_temp_i < WATER_HI);
  end

  always_comb begin
    case (ctrl_i.a_sel)
      A_ERR:   opa = OPND_W'(err_q);
      A_PGAIN: opa = $signed(OPND_W'(cfg_i.prop_gain));
      A_IGAIN: opa = $signed(OPND_W'(cfg_i.integ_gain));
      A_PSU:   opa = $signed(OPND_W'(cfg_i.psu_ratio));
      A_AUX:   opa = $signed(OPND_W'(cfg_i.aux_ratio));
      default: opa = '0;
    endcase
    case (ctrl_i.b_sel)
      B_GAP:   opb = $signed(OPND_W'(gap_q));
      B_ERR:   opb = OPND_W'(err_q);
      B_LO:    opb = $signed(OPND_W'(acc_q[31:0]));
      B_HI:    opb = $signed(OPND_W'(acc_q[ACC_W-1:32]));
      B_LED:   opb = $signed(OPND_W'(led_q));
      default: opb = '0;
    endcase
  end

  always_comb begin
    integ_en  = (err_q > 0) || (acc_q != '0);
    integ_sum = $signed({2'b00, acc_q})
              + (integ_en ? INT_W'($signed(p_q[EG_W-1:0])) : '0);
    integ_lim = $signed({2'b00, cfg_i.integral_limit});
    if (integ_sum > integ_lim) begin
      acc_d = cfg_i.integral_limit;
    end else if (integ_sum < 0) begin
      acc_d = '0;
    end else begin
      acc_d = integ_sum[ACC_W-1:0];
    end
  end

  always_comb begin
    main_sum = (PI_W+1)'(pi_q) + $signed((PI_W+1)'({cfg_i.duty_floor, FRAC_W'(0)}));
    main_cap = $signed((PI_W+1)'({cfg_i.duty_ceiling, FRAC_W'(0)}));
    if (!integ_en) begin
      main_clamp = '0;
    end else if (main_sum > main_cap) begin
      main_clamp = main_cap[DF_W-1:0];
    end else if (main_sum < 0) begin
      main_clamp = '0;
    end else begin
      main_clamp = main_sum[DF_W-1:0];
    end
    main_d = main_clamp[DF_W-1:FRAC_W];

    aux_sum = $signed((PI_W+1)'({DUTY_W'(AUX_FLOOR), FRAC_W'(0)}))
            + ((pi_q > 0) ? (PI_W+1)'(pi_q) : '0);
    aux_cap = $signed((PI_W+1)'({DUTY_W'(AUX_CEILING), FRAC_W'(0)}));
    if (aux_sum > aux_cap) begin
      auxfb_d = DUTY_W'(AUX_CEILING);
    end else begin
      auxfb_d = aux_sum[DF_W-1:FRAC_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_time_q <= '0;
      acc_q       <= '0;
    end else begin
      if (ctrl_i.op == OP_PREP && in_xfer_i) begin
        last_time_q <= now_ms_i;
      end
      if (ctrl_i.op == OP_INTEG) begin
        acc_q <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= opa * opb;
    case (ctrl_i.op)
      OP_PREP: begin
        if (in_xfer_i) begin
          err_q    <= err_d;
          gap_q    <= gap_d;
          led_q    <= led_duty_i;
          wvalid_q <= wvalid_d;
        end
      end
      OP_PI_P:  pi_q <= PI_W'($signed(p_q[PG_W-1:0]));
      OP_PI_LO: pi_q <= pi_q + PI_W'(p_q[63:ILO_SHIFT]);
      OP_PI_HI: pi_q <= pi_q + PI_W'({p_q[39:0], FRAC_W'(0)});
      OP_MAIN: begin
        main_q  <= main_d;
        auxfb_q <= auxfb_d;
        psu_q   <= led_scale(p_q[31:0]);
      end
      default: ;
    endcase
  end

  always_comb begin
    led_on            = led_q != '0;
    aux_led           = led_scale(p_q[31:0]);
    main_out          = wvalid_q ? main_q : '0;
    res_o.main_duty   = main_out;
    res_o.psu_duty    = led_on ? psu_q : main_out;
    res_o.aux_duty    = led_on ? aux_led : auxfb_q;
    res_o.pump_duty   = led_on ? DUTY_W'(PUMP_FULL) : DUTY_W'(PUMP_IDLE);
    res_o.water_valid = wvalid_q;
  end

endmodule

### sv/cpfd_checker.sv
`include "coolant_pi_fan_duty_controller_top_defines.svh"

module cpfd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // A stalled result stays offered and unchanged.
  `CPFD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // After a tick is taken the program runs its steps before the next one.
  `CPFD_ASSERT_NEXT(a_busy_next, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `CPFD_ASSERT_NOW(a_busy_last, s_axis_tvalid && s_axis_tready, ##7 !s_axis_tready)

  // A bad water reading turns the main fan off.
  `CPFD_ASSERT_NOW(a_main_off, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[7:0] == 8'd0)

endmodule

bind coolant_pi_fan_duty_controller_top cpfd_checker u_cpfd_checker (.*);
